FILE: sv/mmcs_pkg.sv
// Package for the min-max contrast stretch core: widths, queue entry type and
// queue sizing. No dependencies; every other file refers to it by scoped names.
package mmcs_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int DATA_W     = 16;
    localparam logic [DATA_W-1:0] PIXEL_MASK = DATA_W'((32'd1 << PIXEL_BITS) - 32'd1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_STEPS   = DATA_W;
    localparam int STEP_BITS   = $clog2(DIV_STEPS);

    // One stretch-pass pixel, classified by the front end
    typedef struct packed {
        logic              zero;   // result is 0 (flat range or pixel at/below minimum)
        logic              sat;    // result saturates to max_value
        logic [DATA_W-1:0] delta;  // pixel - minimum
        logic [DATA_W-1:0] span;   // maximum - minimum
        logic              last;
        logic [DATA_W-1:0] low;
        logic [DATA_W-1:0] high;
    } mmcs_job_t;

endpackage

FILE: sv/min_max_contrast_stretch_core.sv
// Top level of the min-max contrast stretch core: front end, job queue, back end
// and the max_value register. Depends on mmcs_pkg, mmcs_front, mmcs_queue, mmcs_back.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    s_tdata pixel, s_tuser kind, s_tlast last
//   m_*      out  m_tvalid/m_tready    m_tdata stretched|frame_min|frame_max, m_tlast
//   cfg_*    in   cfg_valid/cfg_ready  cfg_data max_value
//
// Measure-pass items update the range registers as they are accepted.
// In the back end a stretch-pass item goes through queue pop, a multiply state,
// 16 restoring divide steps (one quotient bit a step) and result load; a
// flat-range, at-or-below-minimum or saturating pixel goes from pop straight to load.
// Reset clears the range to zero, arms the frame start and sets max_value to 255.
// A two-entry queue holds stretch jobs, so input is taken while the divider works
// or a result waits on m_tready.
module min_max_contrast_stretch_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] pixel
    input  logic        s_tuser,    // [0] kind
    input  logic        s_tlast,    // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [15:0] stretched, [31:16] frame_min, [47:32] frame_max
    output logic        m_tlast,    // last_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data    // max_value
);

    logic [15:0]         max_value_reg;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_not_empty;
    mmcs_pkg::mmcs_job_t push_job;
    mmcs_pkg::mmcs_job_t head_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_value_reg <= 16'd255;
        else if (cfg_valid && cfg_ready)
            max_value_reg <= cfg_data;
    end

    mmcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    mmcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    mmcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_value   (max_value_reg),
        .q_not_empty (q_not_empty),
        .q_head      (head_job),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

FILE: sv/mmcs_front.sv
// Front end: accepts pixel items, tracks the frame minimum and maximum in the
// measure pass and classifies stretch-pass pixels into jobs. Uses mmcs_pkg.
module mmcs_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [15:0] pixel
    input  logic                        s_tuser,   // [0] kind
    input  logic                        s_tlast,   // last
    input  logic                        q_full,
    output logic                        q_push,
    output mmcs_pkg::mmcs_job_t         q_job
);

    logic [mmcs_pkg::DATA_W-1:0] low_reg, low_next;
    logic [mmcs_pkg::DATA_W-1:0] high_reg, high_next;
    logic                        start_reg, start_next;
    logic [mmcs_pkg::DATA_W-1:0] pix;
    logic                        accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign pix      = s_tdata & mmcs_pkg::PIXEL_MASK;
    assign q_push   = accept && s_tuser;

    always_comb
    begin
        low_next   = low_reg;
        high_next  = high_reg;
        start_next = start_reg;
        if (accept && !s_tuser)
        begin
            if (start_reg)
            begin
                low_next  = pix;
                high_next = pix;
            end
            else if (pix > high_reg)
            begin
                high_next = pix;
            end
            else if (pix < low_reg)
            begin
                low_next = pix;
            end
            start_next = s_tlast;
        end
    end

    always_comb
    begin
        q_job.zero  = (high_reg <= low_reg) || (pix <= low_reg);
        q_job.delta = pix - low_reg;
        q_job.span  = high_reg - low_reg;
        q_job.sat   = q_job.delta >= q_job.span;
        q_job.last  = s_tlast;
        q_job.low   = low_reg;
        q_job.high  = high_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= '0;
            high_reg  <= '0;
            start_reg <= 1'b1;
        end
        else
        begin
            low_reg   <= low_next;
            high_reg  <= high_next;
            start_reg <= start_next;
        end
    end

endmodule

FILE: sv/mmcs_queue.sv
// Short job queue between the front end and the divider back end.
// Uses mmcs_pkg for the entry type and depth.
module mmcs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mmcs_pkg::mmcs_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output mmcs_pkg::mmcs_job_t head_job
);

    mmcs_pkg::mmcs_job_t             mem_reg [mmcs_pkg::QUEUE_DEPTH];
    logic [mmcs_pkg::QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [mmcs_pkg::QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [mmcs_pkg::QCNT_BITS-1:0]  count_reg, count_next;
    logic                            do_push, do_pop;

    assign full      = (count_reg == mmcs_pkg::QCNT_BITS'(mmcs_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_job  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == mmcs_pkg::QPTR_BITS'(mmcs_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == mmcs_pkg::QPTR_BITS'(mmcs_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/mmcs_back.sv
// Back end: multiplies the pixel offset by max_value, divides by the range with
// a radix-2 restoring divider and holds the result for the output. Uses mmcs_pkg.
module mmcs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         max_value,
    input  logic                q_not_empty,
    input  mmcs_pkg::mmcs_job_t q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,   // [15:0] stretched, [31:16] frame_min, [47:32] frame_max
    output logic                m_tlast    // last_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [mmcs_pkg::STEP_BITS-1:0]   step_reg;
    mmcs_pkg::mmcs_job_t              job_reg;
    logic [mmcs_pkg::DATA_W-1:0]      rem_reg;
    logic [mmcs_pkg::DATA_W-1:0]      quo_reg;   // low product bits, shifted out as quotient shifts in
    logic [2*mmcs_pkg::DATA_W-1:0]    product;
    logic [mmcs_pkg::DATA_W:0]        rem_shift;
    logic                             rem_ge;
    logic [mmcs_pkg::DATA_W:0]        rem_sub;
    logic [mmcs_pkg::DATA_W-1:0]      result;
    logic                             out_valid_reg;
    logic [47:0]                      out_data_reg;
    logic                             out_last_reg;
    logic                             load_out;

    assign product   = job_reg.delta * max_value;
    assign rem_shift = {rem_reg, quo_reg[mmcs_pkg::DATA_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, job_reg.span};
    assign rem_sub   = rem_shift - {1'b0, job_reg.span};

    assign q_pop    = (state_reg == ST_IDLE) && q_not_empty;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        if (job_reg.zero)
            result = '0;
        else if (job_reg.sat)
            result = max_value;
        else
            result = quo_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    if (q_head.zero || q_head.sat)
                        state_next = ST_DONE;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (step_reg == mmcs_pkg::STEP_BITS'(mmcs_pkg::DIV_STEPS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath: rem starts below span, so sixteen steps give the whole quotient
    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_head;
        if (state_reg == ST_MUL)
        begin
            rem_reg  <= product[2*mmcs_pkg::DATA_W-1:mmcs_pkg::DATA_W];
            quo_reg  <= product[mmcs_pkg::DATA_W-1:0];
            step_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg  <= rem_ge ? rem_sub[mmcs_pkg::DATA_W-1:0]
                               : rem_shift[mmcs_pkg::DATA_W-1:0];
            quo_reg  <= {quo_reg[mmcs_pkg::DATA_W-2:0], rem_ge};
            step_reg <= step_reg + 1'b1;
        end
        if (load_out)
        begin
            out_data_reg <= {job_reg.high, job_reg.low, result};
            out_last_reg <= job_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: tb/sv/min_max_contrast_stretch_core_test.sv
// Self-checking testbench for min_max_contrast_stretch_core: measure and stretch
// passes checked against an in-bench predictor. Depends on mmcs_pkg and the core.
module min_max_contrast_stretch_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_STRETCH = 1'b1;
    localparam int   SETTLE_CYCLES = 30;

    typedef struct {
        logic [15:0] stretched;
        logic        last_out;
        logic [15:0] frame_min;
        logic [15:0] frame_max;
    } stretch_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // Predictor state
    logic [15:0] floor_level = '0;
    logic [15:0] peak_level = '0;
    logic        new_frame = 1'b1;
    logic [15:0] full_scale = 16'd255;

    stretch_result_t stretch_expected[$];
    stretch_result_t checked_result;
    int error_count = 0;
    int send_idle_pct = 23;
    int recv_idle_pct = 63;

    min_max_contrast_stretch_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [15:0] stretched_level(input logic [15:0] level);
        logic [31:0] delta;
        logic [31:0] span;
        logic [31:0] quotient;
        if (peak_level <= floor_level || level <= floor_level)
            return 16'd0;
        delta = {16'd0, level} - {16'd0, floor_level};
        span = {16'd0, peak_level} - {16'd0, floor_level};
        quotient = (delta * {16'd0, full_scale}) / span;
        if (quotient > {16'd0, full_scale})
            quotient = {16'd0, full_scale};
        return quotient[15:0];
    endfunction

    task automatic predict_item(input logic kind, input logic [15:0] pixel, input logic last);
        logic [15:0] level;
        stretch_result_t result;
        level = pixel & mmcs_pkg::PIXEL_MASK;
        if (kind == KIND_MEASURE)
        begin
            if (new_frame)
            begin
                floor_level = level;
                peak_level = level;
            end
            else if (level > peak_level)
                peak_level = level;
            else if (level < floor_level)
                floor_level = level;
            new_frame = last;
        end
        else
        begin
            result.stretched = stretched_level(level);
            result.last_out = last;
            result.frame_min = floor_level;
            result.frame_max = peak_level;
            stretch_expected.push_back(result);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (stretch_expected.size() == 0)
                report_mismatch("result with none expected", m_tdata, '0);
            else
            begin
                checked_result = stretch_expected.pop_front();
                if (m_tdata[15:0] !== checked_result.stretched)
                    report_mismatch("stretched", 48'(m_tdata[15:0]),
                                    48'(checked_result.stretched));
                if (m_tlast !== checked_result.last_out)
                    report_mismatch("last_out", 48'(m_tlast), 48'(checked_result.last_out));
                if (m_tdata[31:16] !== checked_result.frame_min)
                    report_mismatch("frame_min", 48'(m_tdata[31:16]),
                                    48'(checked_result.frame_min));
                if (m_tdata[47:32] !== checked_result.frame_max)
                    report_mismatch("frame_max", 48'(m_tdata[47:32]),
                                    48'(checked_result.frame_max));
            end
        end
    end

    task automatic send_item(input logic kind, input logic [15:0] pixel, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= pixel;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(kind, pixel, last);
    endtask

    // Drop valid, drain all results, then let the back end settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (stretch_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_full_scale(input logic [15:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        full_scale = value;
    endtask

    task automatic test_flat_and_unmeasured();
        // Range still at its reset value: flat
        send_item(KIND_STRETCH, 16'h1234, 1'b0);
        send_item(KIND_STRETCH, 16'hFFFF, 1'b1);
        send_item(KIND_MEASURE, 16'h4242, 1'b1);
        send_item(KIND_STRETCH, 16'h4242, 1'b0);
        send_item(KIND_STRETCH, 16'h0000, 1'b0);
        send_item(KIND_STRETCH, 16'hFFFF, 1'b1);
    endtask

    task automatic test_full_range();
        send_item(KIND_MEASURE, 16'h0000, 1'b0);
        send_item(KIND_MEASURE, 16'hFFFF, 1'b0);
        send_item(KIND_MEASURE, 16'h8000, 1'b1);
        send_item(KIND_STRETCH, 16'h0000, 1'b0);
        send_item(KIND_STRETCH, 16'hFFFF, 1'b0);
        send_item(KIND_STRETCH, 16'h7FFF, 1'b0);
        send_item(KIND_STRETCH, 16'h0001, 1'b1);
    endtask

    task automatic test_stretch_during_measure();
        send_item(KIND_MEASURE, 16'd1000, 1'b0);
        send_item(KIND_MEASURE, 16'd500, 1'b0);
        send_item(KIND_STRETCH, 16'd700, 1'b0);
        send_item(KIND_MEASURE, 16'd2000, 1'b1);
        send_item(KIND_STRETCH, 16'd300, 1'b0);
        send_item(KIND_STRETCH, 16'd2500, 1'b0);
        send_item(KIND_STRETCH, 16'd1250, 1'b1);
    endtask

    task automatic test_full_scale_extremes();
        logic [15:0] scales[3];
        int i;
        scales = '{16'hFFFF, 16'd1, 16'd0};
        for (i = 0; i < 3; i++)
        begin
            write_full_scale(scales[i]);
            send_item(KIND_STRETCH, 16'd1250, 1'b0);
            send_item(KIND_STRETCH, 16'd2000, 1'b1);
        end
    endtask

    // Mostly measure frame then stretch frame; some noise and broken frames
    task automatic run_random_frames(input int item_budget);
        logic [15:0] frame_pixels[$];
        logic [15:0] base;
        logic [15:0] pixel;
        int sent;
        int count;
        int spread;
        int i;
        logic drop_last;
        sent = 0;
        while (sent < item_budget)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_item(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                count = $urandom_range(1, 12);
                base = 16'($urandom);
                case ($urandom_range(2))
                    0: spread = 0;
                    1: spread = $urandom_range(1, 300);
                    default: spread = 65535;
                endcase
                drop_last = ($urandom_range(9) == 0);
                frame_pixels.delete();
                for (i = 0; i < count; i++)
                begin
                    pixel = base + 16'($urandom_range(spread));
                    frame_pixels.push_back(pixel);
                    send_item(KIND_MEASURE, pixel, (i == count - 1) && !drop_last);
                end
                for (i = 0; i < count; i++)
                begin
                    pixel = ($urandom_range(4) == 0) ? 16'($urandom) : frame_pixels[i];
                    send_item(KIND_STRETCH, pixel, i == count - 1);
                end
                sent += 2 * count;
            end
        end
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct,
                                    input logic [15:0] first_scale,
                                    input logic [15:0] second_scale);
        wait_idle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_full_scale(first_scale);
        run_random_frames(225);
        write_full_scale(second_scale);
        run_random_frames(225);
    endtask

    task automatic test_random_traffic();
        run_random_phase(23, 63, 16'($urandom_range(1, 65535)), 16'hFFFF);
        run_random_phase(63, 23, 16'($urandom_range(1, 15)), 16'($urandom_range(1, 65535)));
        run_random_phase(0, 0, 16'd1, 16'd255);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_flat_and_unmeasured();
        test_full_range();
        test_stretch_during_measure();
        test_full_scale_extremes();
        test_random_traffic();
        wait_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
